### hw/rtl/aplm_pkg.sv
// Package for the audio peak level meter: format codes, register indexes,
// controller states and the command and status structs.
// Depends on nothing; every other file of the block uses it.
package aplm_pkg;

    // Fraction bits of the level output; the level holds one more bit for 1.0.
    localparam int LEVEL_FRACTION_BITS = 16;
    localparam int LEVEL_W             = LEVEL_FRACTION_BITS + 1;

    // The divider produces one quotient bit per step.
    localparam int DIV_STEPS = LEVEL_FRACTION_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sample width codes.
    localparam logic [1:0] BITS_8  = 2'd0;
    localparam logic [1:0] BITS_16 = 2'd1;
    localparam logic [1:0] BITS_32 = 2'd2;

    // Sample kind codes.
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_BITS = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_KIND = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN0,
        ST_DRAIN1,
        ST_CLAMP,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clamp;
        logic div_step;
        logic div_first;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fmt_ok;
        logic out_free;
    } status_t;

    // Full scale of a format, zero when the format is not supported.
    function automatic logic [31:0] full_scale(input logic [1:0] bits, input logic [1:0] kind);
        logic [31:0] fs;
        fs = 32'd0;
        unique case (bits)
            BITS_8: begin
                if (kind == KIND_UNSIGNED) fs = 32'd255;
                else if (kind == KIND_SIGNED) fs = 32'd127;
            end
            BITS_16: begin
                if (kind == KIND_UNSIGNED) fs = 32'd65535;
                else if (kind == KIND_SIGNED) fs = 32'd32767;
            end
            BITS_32: begin
                if (kind == KIND_UNSIGNED) fs = 32'hffff_ffff;
                else if (kind == KIND_SIGNED || kind == KIND_FLOAT) fs = 32'h7fff_ffff;
            end
            default: fs = 32'd0;
        endcase
        return fs;
    endfunction

endpackage

### hw/rtl/aplm_ctrl.sv
// Controller of the audio peak level meter: sequences byte intake, pipeline
// drain, peak clamping, the bit-serial division and the result hand-off.
// Depends on aplm_pkg.
module aplm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last_byte,
    output logic             s_ready,
    input  aplm_pkg::status_t status,
    output aplm_pkg::cmd_t    cmd
);

    localparam logic [aplm_pkg::DIV_CNT_W-1:0] CNT_LAST =
        aplm_pkg::DIV_CNT_W'(aplm_pkg::DIV_STEPS - 1);

    aplm_pkg::state_t state_reg, state_next;
    logic [aplm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // State and step counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aplm_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            aplm_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_last_byte) begin
                    // An unsupported format skips straight to the result.
                    state_next = status.fmt_ok ? aplm_pkg::ST_DRAIN0 : aplm_pkg::ST_EMIT;
                end
            end
            aplm_pkg::ST_DRAIN0: state_next = aplm_pkg::ST_DRAIN1;
            aplm_pkg::ST_DRAIN1: state_next = aplm_pkg::ST_CLAMP;
            aplm_pkg::ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                cnt_next   = '0;
                state_next = aplm_pkg::ST_DIV;
            end
            aplm_pkg::ST_DIV: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = aplm_pkg::ST_EMIT;
                end
            end
            aplm_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = aplm_pkg::ST_IDLE;
                end
            end
            default: state_next = aplm_pkg::ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/aplm_datapath.sv
// Datapath of the audio peak level meter: configuration registers, sample
// assembly, magnitude pipeline, running peak, divider and output register.
// Depends on aplm_pkg.
module aplm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_last_byte,
    input  aplm_pkg::cmd_t                cmd,
    output aplm_pkg::status_t             status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [aplm_pkg::LEVEL_W-1:0]  m_level_q16,
    output logic [31:0]                   m_peak_value
);

    localparam int LW = aplm_pkg::LEVEL_W;

    // Float sample to floor(|f| * 2^31), saturating.
    function automatic logic [31:0] float_mag(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [23:0] man;
        logic [7:0]  lsh;
        logic [7:0]  rsh;
        logic [31:0] res;
        ex  = bits[30:23];
        man = {1'b1, bits[22:0]};
        lsh = ex - 8'd119;
        rsh = 8'd119 - ex;
        if (ex == 8'd0) res = 32'd0;
        else if (ex >= 8'd128) res = 32'hffff_ffff;
        else if (ex >= 8'd119) res = {8'd0, man} << lsh[3:0];
        else if (rsh >= 8'd24) res = 32'd0;
        else res = {8'd0, man} >> rsh[4:0];
        return res;
    endfunction

    logic [1:0]    cfg_bits_reg, cfg_kind_reg;
    logic          cfg_be_reg;
    logic [1:0]    pos_reg;
    logic [31:0]   asm_reg;
    logic [31:0]   smp_reg;
    logic [1:0]    smp_bits_reg, smp_kind_reg;
    logic          smp_vld_reg;
    logic [31:0]   mag_reg, mag_next;
    logic          mag_vld_reg;
    logic [31:0]   peak_reg;
    logic [31:0]   hold_reg;
    logic [31:0]   rem_reg;
    logic [LW-1:0] quo_reg;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] out_level_reg;
    logic [31:0]   out_peak_reg;
    logic          out_vld_reg;

    logic [31:0] fs;
    logic        fmt_ok;
    logic [1:0]  last_pos;
    logic [31:0] asm_new;
    logic [31:0] swapped;
    logic        complete;
    logic [32:0] rem_in;
    logic [32:0] rem_diff;
    logic        ge;
    logic [LW-1:0] emit_level;

    assign fs     = aplm_pkg::full_scale(cfg_bits_reg, cfg_kind_reg);
    assign fmt_ok = (fs != 32'd0);

    assign status.fmt_ok   = fmt_ok;
    assign status.out_free = !out_vld_reg || m_ready;

    // Configuration registers; a write beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_bits_reg <= aplm_pkg::BITS_16;
            cfg_kind_reg <= aplm_pkg::KIND_SIGNED;
            cfg_be_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                aplm_pkg::CFG_SAMPLE_BITS: cfg_bits_reg <= cfg_data;
                aplm_pkg::CFG_SAMPLE_KIND: cfg_kind_reg <= cfg_data;
                aplm_pkg::CFG_BIG_ENDIAN:  cfg_be_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Byte assembly: bytes are placed in arrival order, first byte lowest.
    always_comb begin
        case (cfg_bits_reg)
            aplm_pkg::BITS_8:  last_pos = 2'd0;
            aplm_pkg::BITS_16: last_pos = 2'd1;
            default:           last_pos = 2'd3;
        endcase
        asm_new  = ((pos_reg == 2'd0) ? 32'd0 : asm_reg) |
                   ({24'd0, s_data_byte} << {pos_reg, 3'b000});
        complete = (pos_reg >= last_pos);
        swapped  = asm_new;
        if (cfg_be_reg) begin
            case (cfg_bits_reg)
                aplm_pkg::BITS_16: swapped = {16'd0, asm_new[7:0], asm_new[15:8]};
                aplm_pkg::BITS_32: swapped = {asm_new[7:0], asm_new[15:8],
                                              asm_new[23:16], asm_new[31:24]};
                default:           swapped = asm_new;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 2'd0;
            asm_reg     <= 32'd0;
            smp_vld_reg <= 1'b0;
        end else begin
            smp_vld_reg <= cmd.accept && fmt_ok && complete;
            if (cmd.accept) begin
                if (!fmt_ok || s_last_byte || complete) begin
                    pos_reg <= 2'd0;
                    asm_reg <= 32'd0;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                    asm_reg <= asm_new;
                end
            end
        end
    end

    // The completed sample is held with the format it was taken in.
    always_ff @(posedge aclk) begin
        if (cmd.accept && fmt_ok && complete) begin
            smp_reg      <= swapped;
            smp_bits_reg <= cfg_bits_reg;
            smp_kind_reg <= cfg_kind_reg;
        end
    end

    // Magnitude of the held sample.
    always_comb begin
        logic        sign;
        logic [31:0] base;
        logic [31:0] mask;
        logic [31:0] diff;
        case (smp_bits_reg)
            aplm_pkg::BITS_8: begin
                sign = smp_reg[7];
                base = 32'h0000_0100;
                mask = 32'h0000_01ff;
            end
            aplm_pkg::BITS_16: begin
                sign = smp_reg[15];
                base = 32'h0001_0000;
                mask = 32'h0001_ffff;
            end
            default: begin
                sign = smp_reg[31];
                base = 32'd0;
                mask = 32'hffff_ffff;
            end
        endcase
        diff = base - smp_reg;
        case (smp_kind_reg)
            aplm_pkg::KIND_UNSIGNED: mag_next = smp_reg;
            aplm_pkg::KIND_FLOAT:    mag_next = float_mag(smp_reg);
            default:                 mag_next = sign ? (diff & mask) : smp_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_vld_reg <= 1'b0;
        end else begin
            mag_vld_reg <= smp_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (smp_vld_reg) begin
            mag_reg <= mag_next;
        end
    end

    // Running peak, restarted when a result is handed over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= 32'd0;
        end else if (cmd.emit) begin
            peak_reg <= 32'd0;
        end else if (mag_vld_reg && (mag_reg > peak_reg)) begin
            peak_reg <= mag_reg;
        end
    end

    // Restoring division, one quotient bit per step; the remainder stays below fs.
    assign rem_in   = cmd.div_first ? {1'b0, hold_reg} : {rem_reg, 1'b0};
    assign rem_diff = rem_in - {1'b0, fs};
    assign ge       = (rem_in >= {1'b0, fs});

    always_ff @(posedge aclk) begin
        if (cmd.clamp) begin
            hold_reg <= (peak_reg < fs) ? peak_reg : fs;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? rem_diff[31:0] : rem_in[31:0];
            quo_reg <= {quo_reg[LW-2:0], ge};
        end
    end

    // An unsupported format repeats the previous level.
    assign emit_level = fmt_ok ? quo_reg : level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (cmd.emit) begin
            level_reg   <= emit_level;
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_level_reg <= emit_level;
            out_peak_reg  <= fmt_ok ? hold_reg : 32'd0;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_level_q16  = out_level_reg;
    assign m_peak_value = out_peak_reg;

endmodule

### hw/rtl/audio_peak_level_meter_unit.sv
// Audio peak level meter, top level: joins the controller and the datapath.
// Ordinary bytes are taken one per cycle; a last byte holds the input through the
// magnitude pipeline drain (ST_DRAIN0, ST_DRAIN1), the clamp, 17 divider steps and the
// hand-off, or through the hand-off alone when the format is unsupported.
// The hand-off waits until the output is free. Synchronous active-low reset sets width
// 16 bits, signed, little endian, and clears the controller, byte assembly, peak, held
// level and valid flags. Depends on aplm_pkg, aplm_ctrl, aplm_datapath.
module audio_peak_level_meter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [1:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [aplm_pkg::LEVEL_W-1:0]  m_level_q16,
    output logic [31:0]                   m_peak_value
);

    aplm_pkg::cmd_t    cmd;
    aplm_pkg::status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    aplm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    aplm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level_q16  (m_level_q16),
        .m_peak_value (m_peak_value)
    );

endmodule

### tb/tb_audio_peak_level_meter_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for audio_peak_level_meter_unit: directed and random byte streams
// are checked against a level predictor kept in step with every accepted transaction.
// Depends on aplm_pkg and the RTL of audio_peak_level_meter_unit.
module tb_audio_peak_level_meter_unit;

    // Codes the package leaves unnamed.
    localparam logic [1:0] BITS_UNSUPPORTED = 2'd3;
    localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 30;
    localparam int END_CYCLES   = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 470;

    typedef struct packed {
        logic [aplm_pkg::LEVEL_W-1:0] level;
        logic [31:0]                  peak;
    } level_reading_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [1:0]                    cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_data_byte;
    logic                          s_last_byte;
    logic                          m_valid;
    logic                          m_ready;
    logic [aplm_pkg::LEVEL_W-1:0]  m_level_q16;
    logic [31:0]                   m_peak_value;

    // Predictor copy of the configuration and the metering state.
    logic [1:0]                    meter_bits       = aplm_pkg::BITS_16;
    logic [1:0]                    meter_kind       = aplm_pkg::KIND_SIGNED;
    logic                          meter_big_endian = 1'b0;
    logic [31:0]                   assembly         = 32'd0;
    logic [1:0]                    byte_pos         = 2'd0;
    logic [31:0]                   running_peak     = 32'd0;
    logic [aplm_pkg::LEVEL_W-1:0]  held_level       = '0;

    level_reading_t      expected_levels[$];
    int unsigned         error_count      = 0;
    int unsigned         cycle_count      = 0;
    int unsigned         bytes_counted    = 0;
    int unsigned         sender_idle_pct  = 0;
    int unsigned         receiver_stall_pct = 0;
    int                  hold_off_cycles  = 0;

    audio_peak_level_meter_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_level_q16  (m_level_q16),
        .m_peak_value (m_peak_value)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Full scale of a format; zero marks a format that the meter does not support.
    function automatic logic [31:0] format_full_scale(input logic [1:0] bits,
                                                      input logic [1:0] kind);
        logic [31:0] scale;
        case ({bits, kind})
            {aplm_pkg::BITS_8,  aplm_pkg::KIND_UNSIGNED}: scale = 32'd255;
            {aplm_pkg::BITS_8,  aplm_pkg::KIND_SIGNED}:   scale = 32'd127;
            {aplm_pkg::BITS_16, aplm_pkg::KIND_UNSIGNED}: scale = 32'd65535;
            {aplm_pkg::BITS_16, aplm_pkg::KIND_SIGNED}:   scale = 32'd32767;
            {aplm_pkg::BITS_32, aplm_pkg::KIND_UNSIGNED}: scale = 32'hffff_ffff;
            {aplm_pkg::BITS_32, aplm_pkg::KIND_SIGNED}:   scale = 32'h7fff_ffff;
            {aplm_pkg::BITS_32, aplm_pkg::KIND_FLOAT}:    scale = 32'h7fff_ffff;
            default:                                      scale = 32'd0;
        endcase
        return scale;
    endfunction

    // Single precision value to floor(|f| * 2^31), saturating at all ones.
    function automatic logic [31:0] float_to_fixed(input logic [31:0] word);
        logic [7:0]  expo;
        logic [31:0] mant;
        expo = word[30:23];
        mant = {8'd0, 1'b1, word[22:0]};
        if (expo == 8'd0) return 32'd0;
        if (expo >= 8'd128) return 32'hffff_ffff;
        if (expo >= 8'd119) return mant << (expo - 8'd119);
        if (8'd119 - expo >= 8'd24) return 32'd0;
        return mant >> (8'd119 - expo);
    endfunction

    // Magnitude of one assembled sample under the current configuration.
    function automatic logic [31:0] sample_magnitude(input logic [31:0] raw,
                                                     input int unsigned width_bytes);
        logic [31:0] word;
        word = raw;
        if (meter_big_endian) begin
            if (width_bytes == 2) word = {16'd0, raw[7:0], raw[15:8]};
            else if (width_bytes == 4) word = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
        end
        if (meter_kind == aplm_pkg::KIND_UNSIGNED) return word;
        if (meter_kind == aplm_pkg::KIND_FLOAT) return float_to_fixed(word);
        // Bytes left over from a wider format may sit above the sample; the mask keeps
        // the negation within one bit above the sample width.
        if (width_bytes == 1) return word[7] ? ((32'h100 - word) & 32'h1ff) : word;
        if (width_bytes == 2) return word[15] ? ((32'h10000 - word) & 32'h1ffff) : word;
        return word[31] ? 32'd0 - word : word;
    endfunction

    // Advances the predictor by one accepted byte and queues the reading it causes.
    task automatic meter_step(input logic [7:0] data, input logic last);
        logic [31:0]    scale;
        logic [31:0]    mag;
        logic [63:0]    quotient;
        int unsigned    width_bytes;
        int unsigned    pos;
        level_reading_t reading;
        scale = format_full_scale(meter_bits, meter_kind);
        if (scale != 32'd0) begin
            bytes_counted++;
            width_bytes = 1 << meter_bits;
            pos = byte_pos;
            if (pos == 0) assembly = 32'd0;
            assembly = assembly | ({24'd0, data} << (8 * pos));
            if (pos + 1 >= width_bytes) begin
                mag = sample_magnitude(assembly, width_bytes);
                if (mag > running_peak) running_peak = mag;
                byte_pos = 2'd0;
                assembly = 32'd0;
            end else begin
                byte_pos = 2'(pos + 1);
            end
        end else begin
            byte_pos = 2'd0;
            assembly = 32'd0;
        end
        if (last) begin
            reading.peak = 32'd0;
            if (scale != 32'd0) begin
                reading.peak = (running_peak < scale) ? running_peak : scale;
                quotient = ({32'd0, reading.peak} << aplm_pkg::LEVEL_FRACTION_BITS) /
                           {32'd0, scale};
                held_level = quotient[aplm_pkg::LEVEL_W-1:0];
            end
            reading.level = held_level;
            expected_levels.push_back(reading);
            running_peak = 32'd0;
            byte_pos = 2'd0;
            assembly = 32'd0;
        end
    endtask

    // Sends one byte as an input transaction, with random idling before it.
    task automatic send_byte(input logic [7:0] data, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = data;
        s_last_byte = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        meter_step(data, last);
    endtask

    // Sends the first count bytes of a sample in the configured byte order.
    task automatic send_sample(input logic [31:0] value, input int unsigned width_bytes,
                               input int unsigned count, input logic last);
        int unsigned idx;
        for (int unsigned i = 0; i < count; i++) begin
            idx = meter_big_endian ? width_bytes - 1 - i : i;
            send_byte(value[8*idx +: 8], last && (i == count - 1));
        end
    endtask

    // Waits until every reading has arrived and the pipeline has gone quiet.
    task automatic drain_meter();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            aplm_pkg::CFG_SAMPLE_BITS: meter_bits = data;
            aplm_pkg::CFG_SAMPLE_KIND: meter_kind = data;
            aplm_pkg::CFG_BIG_ENDIAN:  meter_big_endian = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Reconfigures the meter once it is idle; all three registers are written.
    task automatic configure_meter(input logic [1:0] bits, input logic [1:0] kind,
                                   input logic [1:0] order);
        drain_meter();
        write_register(aplm_pkg::CFG_SAMPLE_BITS, bits);
        write_register(aplm_pkg::CFG_SAMPLE_KIND, kind);
        write_register(aplm_pkg::CFG_BIG_ENDIAN, order);
    endtask

    // Random sample word biased towards the extremes of the current format.
    function automatic logic [31:0] pick_sample(input int unsigned width_bytes);
        logic [31:0] mask;
        logic [31:0] sign_bit;
        logic [31:0] word;
        logic [7:0]  expo_pick;
        mask      = (width_bytes == 4) ? 32'hffff_ffff : (32'd1 << (8 * width_bytes)) - 1;
        sign_bit  = 32'd1 << (8 * width_bytes - 1);
        word      = $urandom;
        expo_pick = 8'($urandom_range(94, 128));
        if (meter_kind == aplm_pkg::KIND_FLOAT) begin
            case ($urandom_range(9))
                0: word = {word[31], 31'd0};
                1: word = {word[31], 8'hff, 23'd0};
                2: word = {word[31], 8'hff, word[22:0] | 23'd1};
                3: word = {word[31], 8'd0, word[22:0]};
                4: word = {word[31], 8'd127, word[22:0]};
                5, 6, 7: word[30:23] = expo_pick;
                default: ;
            endcase
        end else begin
            case ($urandom_range(7))
                0: word = 32'd0;
                1: word = mask;
                2: word = sign_bit;
                3: word = sign_bit - 1;
                4: word = sign_bit + 1;
                default: ;
            endcase
        end
        return word & mask;
    endfunction

    // A buffer of whole samples, maybe a partial one last; 1 to 3 bytes if unsupported.
    task automatic send_random_buffer();
        int unsigned width_bytes;
        int unsigned samples;
        int unsigned partial;
        int unsigned count;
        if (format_full_scale(meter_bits, meter_kind) == 32'd0) begin
            count = $urandom_range(1, 3);
            for (int unsigned i = 0; i < count; i++) send_byte(8'($urandom), i == count - 1);
        end else begin
            width_bytes = 1 << meter_bits;
            samples = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            partial = ($urandom_range(7) == 0) ? $urandom_range(width_bytes - 1) : 0;
            for (int unsigned s = 0; s < samples; s++) begin
                send_sample(pick_sample(width_bytes), width_bytes, width_bytes,
                            (partial == 0) && (s == samples - 1));
            end
            if (partial != 0) send_sample(pick_sample(width_bytes), width_bytes, partial, 1'b1);
        end
    endtask

    // A random configuration followed by a few buffers; sometimes a sample is left open.
    task automatic send_random_segment();
        logic [1:0]  bits;
        logic [1:0]  kind;
        int unsigned buffers;
        int unsigned width_bytes;
        if ($urandom_range(11) == 0) begin
            bits = BITS_UNSUPPORTED;
            kind = 2'($urandom_range(3));
        end else begin
            bits = 2'($urandom_range(2));
            kind = (bits == aplm_pkg::BITS_32) ? 2'($urandom_range(2)) : 2'($urandom_range(1));
            if ($urandom_range(14) == 0) begin
                kind = 2'($urandom_range(aplm_pkg::KIND_FLOAT, KIND_UNSUPPORTED));
            end
        end
        configure_meter(bits, kind, 2'($urandom_range(3)));
        buffers = $urandom_range(1, 4);
        repeat (buffers) send_random_buffer();
        // An open sample carries over into the next configuration.
        width_bytes = 1 << meter_bits;
        if (format_full_scale(meter_bits, meter_kind) != 32'd0 && width_bytes > 1 &&
            $urandom_range(7) == 0) begin
            send_sample(pick_sample(width_bytes), width_bytes,
                        $urandom_range(1, width_bytes - 1), 1'b0);
        end
    endtask

    // Default format after reset: 16-bit signed, little endian.
    task automatic test_reset_defaults();
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_eight_bit_extremes();
        configure_meter(aplm_pkg::BITS_8, aplm_pkg::KIND_UNSIGNED, 2'd0);
        send_byte(8'hff, 1'b1);
        configure_meter(aplm_pkg::BITS_8, aplm_pkg::KIND_SIGNED, 2'd0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Half scale, then a NaN that saturates and is clamped.
    task automatic test_float_special_values();
        configure_meter(aplm_pkg::BITS_32, aplm_pkg::KIND_FLOAT, 2'd1);
        send_sample(32'h3f00_0000, 4, 4, 1'b1);
        send_sample(32'h7fc0_0001, 4, 4, 1'b1);
    endtask

    // Unsupported formats ignore bytes and repeat the previous level.
    task automatic test_unsupported_format();
        drain_meter();
        write_register(CFG_UNUSED_INDEX, 2'd3);
        configure_meter(BITS_UNSUPPORTED, aplm_pkg::KIND_SIGNED, 2'd0);
        send_byte(8'h55, 1'b1);
        configure_meter(aplm_pkg::BITS_8, KIND_UNSUPPORTED, 2'd1);
        send_byte(8'haa, 1'b1);
        configure_meter(aplm_pkg::BITS_16, aplm_pkg::KIND_FLOAT, 2'd0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_partial_trailing_sample();
        configure_meter(aplm_pkg::BITS_32, aplm_pkg::KIND_UNSIGNED, 2'd0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // A 32-bit sample begun, then finished as a 16-bit one.
    task automatic test_midsample_reconfig();
        configure_meter(aplm_pkg::BITS_32, aplm_pkg::KIND_UNSIGNED, 2'd0);
        send_byte(8'h12, 1'b0);
        configure_meter(aplm_pkg::BITS_16, aplm_pkg::KIND_UNSIGNED, 2'd0);
        send_byte(8'h34, 1'b1);
    endtask

    // The receiver holds off long enough for the meter to stall its input.
    task automatic test_output_backpressure();
        configure_meter(aplm_pkg::BITS_8, aplm_pkg::KIND_UNSIGNED, 2'd0);
        hold_off_cycles = 300;
        repeat (20) send_byte(8'($urandom), 1'b1);
        drain_meter();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned goal;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        goal = bytes_counted + PHASE_BYTES;
        while (bytes_counted < goal) send_random_segment();
        drain_meter();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready = 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Each result transaction is compared with the oldest expected reading.
    always @(posedge aclk) begin : check_results
        level_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected result, level %0d peak %0h",
                         $time, m_level_q16, m_peak_value);
                error_count++;
            end else begin
                want = expected_levels.pop_front();
                if (m_level_q16 !== want.level) begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, want.level, m_level_q16);
                    error_count++;
                end
                if (m_peak_value !== want.peak) begin
                    $display("%0t: peak mismatch, expected %0h, actual %0h",
                             $time, want.peak, m_peak_value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("audio_peak_level_meter_unit verification failed");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = aplm_pkg::CFG_SAMPLE_BITS;
        cfg_data    = 2'd0;
        s_valid     = 1'b0;
        s_data_byte = 8'd0;
        s_last_byte = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_eight_bit_extremes();
        test_float_special_values();
        test_unsupported_format();
        test_partial_trailing_sample();
        test_midsample_reconfig();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(80, 0);
        test_random_traffic(0, 80);
        test_random_traffic(38, 38);

        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("audio_peak_level_meter_unit verification clean");
        end else begin
            $display("audio_peak_level_meter_unit verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/aplm_pkg.sv
hw/rtl/aplm_ctrl.sv
hw/rtl/aplm_datapath.sv
hw/rtl/audio_peak_level_meter_unit.sv
tb/tb_audio_peak_level_meter_unit.sv
